>>> sv/qstm_pkg.sv
// ----------------------------------------------------------------------------
// qstm_pkg: shared types and constants for the quaternion transform pipeline
// Fixed-point formats, rotation element ordering and rounding constants.
// ----------------------------------------------------------------------------
package qstm_pkg;

	localparam int QW       = 16;  // quaternion component width
	localparam int VW       = 32;  // scale, translation, result, rotation width
	localparam int SUMW     = 33;  // pair sum of two 16x16 products
	localparam int KW       = 64;  // wide product width
	localparam int NROT     = 9;   // rotation elements
	localparam int NPROD    = 9;   // distinct quaternion products
	localparam int DBL_SHIFT = 31; // 2*P*K / 2^32 == P*K / 2^31
	localparam int ROT_FRAC  = 28;

	// 1/32767^2 in Q60
	localparam logic signed [VW-1:0] KSQ     = 32'sd1073807363;
	localparam logic signed [VW-1:0] ROT_ONE = 32'sd268435456;

	localparam logic signed [KW-1:0] DBL_BIAS = (64'sd1 <<< DBL_SHIFT) - 64'sd1;
	localparam logic signed [KW-1:0] ROT_BIAS = (64'sd1 <<< ROT_FRAC) - 64'sd1;
	localparam logic signed [KW-1:0] SAT_MAX  = 64'sd2147483647;
	localparam logic signed [KW-1:0] SAT_MIN  = -64'sd2147483648;

	// product slots
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_XY = 3;
	localparam int P_XZ = 4;
	localparam int P_YZ = 5;
	localparam int P_WX = 6;
	localparam int P_WY = 7;
	localparam int P_WZ = 8;

	// rotation elements in column order; diagonal ones are 1 - R
	localparam logic [NROT-1:0] DIAG_MASK = 9'b100010001;

	typedef logic signed [QW-1:0] quat_comp_t;
	typedef logic signed [VW-1:0] val_t;

	typedef struct packed {
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
		quat_comp_t w;
	} quat_t;

	typedef struct packed {
		val_t x;
		val_t y;
		val_t z;
	} vec3_t;

	typedef val_t rot_vec_t [NROT];

endpackage

>>> sv/qstm_rot.sv
// ----------------------------------------------------------------------------
// qstm_rot: quaternion to Q28 rotation matrix
// Five stages: products, pair sums, constant multiply, truncation, diagonal.
// ----------------------------------------------------------------------------
module qstm_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qstm_pkg::quat_t   quat,
	output logic              out_valid,
	output qstm_pkg::rot_vec_t rot
);
	import qstm_pkg::*;

	logic signed [VW-1:0]   prod_s1 [NPROD];
	logic signed [SUMW-1:0] sum_s2  [NROT];
	logic signed [KW-1:0]   kp_s3   [NROT];
	logic signed [KW-1:0]   kb      [NROT];
	val_t                   r_s4    [NROT];
	val_t                   m_s5    [NROT];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1[P_XX] <= VW'(quat.x * quat.x);
		prod_s1[P_YY] <= VW'(quat.y * quat.y);
		prod_s1[P_ZZ] <= VW'(quat.z * quat.z);
		prod_s1[P_XY] <= VW'(quat.x * quat.y);
		prod_s1[P_XZ] <= VW'(quat.x * quat.z);
		prod_s1[P_YZ] <= VW'(quat.y * quat.z);
		prod_s1[P_WX] <= VW'(quat.w * quat.x);
		prod_s1[P_WY] <= VW'(quat.w * quat.y);
		prod_s1[P_WZ] <= VW'(quat.w * quat.z);
	end

	// products are full 32 bit signed; widen before sum
	always_ff @(posedge clk) begin
		sum_s2[0] <= SUMW'(prod_s1[P_YY]) + SUMW'(prod_s1[P_ZZ]);
		sum_s2[1] <= SUMW'(prod_s1[P_XY]) + SUMW'(prod_s1[P_WZ]);
		sum_s2[2] <= SUMW'(prod_s1[P_XZ]) - SUMW'(prod_s1[P_WY]);
		sum_s2[3] <= SUMW'(prod_s1[P_XY]) - SUMW'(prod_s1[P_WZ]);
		sum_s2[4] <= SUMW'(prod_s1[P_XX]) + SUMW'(prod_s1[P_ZZ]);
		sum_s2[5] <= SUMW'(prod_s1[P_YZ]) + SUMW'(prod_s1[P_WX]);
		sum_s2[6] <= SUMW'(prod_s1[P_XZ]) + SUMW'(prod_s1[P_WY]);
		sum_s2[7] <= SUMW'(prod_s1[P_YZ]) - SUMW'(prod_s1[P_WX]);
		sum_s2[8] <= SUMW'(prod_s1[P_XX]) + SUMW'(prod_s1[P_YY]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NROT; i++) begin
			kp_s3[i] <= KW'(sum_s2[i]) * KW'(KSQ);
		end
	end

	// truncate toward zero: bias negatives before the arithmetic shift
	always_comb begin
		for (int i = 0; i < NROT; i++) begin
			kb[i] = kp_s3[i] + (kp_s3[i][KW-1] ? DBL_BIAS : '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NROT; i++) begin
			r_s4[i] <= VW'(kb[i] >>> DBL_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NROT; i++) begin
			m_s5[i] <= DIAG_MASK[i] ? (ROT_ONE - r_s4[i]) : r_s4[i];
		end
	end

	assign out_valid = v_s5;
	assign rot       = m_s5;

endmodule

>>> sv/qstm_scale.sv
// ----------------------------------------------------------------------------
// qstm_scale: column scaling of the rotation matrix
// Two stages: Q28 x Q16.16 multiply, then truncation and saturation.
// ----------------------------------------------------------------------------
module qstm_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qstm_pkg::rot_vec_t rot,
	input  qstm_pkg::vec3_t    scale,
	output logic               out_valid,
	output qstm_pkg::rot_vec_t res
);
	import qstm_pkg::*;

	logic signed [KW-1:0] prod_s6 [NROT];
	logic signed [KW-1:0] pb      [NROT];
	logic signed [KW-1:0] q       [NROT];
	val_t                 res_s7  [NROT];
	val_t                 col_scale [3];
	logic v_s6, v_s7;

	assign col_scale[0] = scale.x;
	assign col_scale[1] = scale.y;
	assign col_scale[2] = scale.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= in_valid;
			v_s7 <= v_s6;
		end
	end

	for (genvar i = 0; i < NROT; i++) begin : g_elem
		always_ff @(posedge clk) begin
			prod_s6[i] <= KW'(rot[i]) * KW'(col_scale[i / 3]);
		end

		always_comb begin
			pb[i] = prod_s6[i] + (prod_s6[i][KW-1] ? ROT_BIAS : '0);
			q[i]  = pb[i] >>> ROT_FRAC;
		end

		always_ff @(posedge clk) begin
			if (q[i] > SAT_MAX) begin
				res_s7[i] <= VW'(SAT_MAX);
			end else if (q[i] < SAT_MIN) begin
				res_s7[i] <= VW'(SAT_MIN);
			end else begin
				res_s7[i] <= VW'(q[i]);
			end
		end
	end

	assign out_valid = v_s7;
	assign res       = res_s7;

endmodule

>>> sv/quat_scale_translate_matrix.sv
// ----------------------------------------------------------------------------
// quat_scale_translate_matrix: quaternion, scale, translation to 3x4 matrix
// Builds the scaled rotation columns and passes the translation through.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive quat_*, scale_*, move_* and raise start. A request
//   is taken at every rising edge with start high and busy low. busy is
//   always low: the pipeline takes one request per cycle, every cycle.
//   Result channel: done is high for one cycle with col*_* and tr_* valid;
//   the receiver takes it at the edge that ends that cycle and cannot stall.
//   Path: a request passes through the seven register stages (products,
//   pair sums, constant multiply, truncation, diagonal, scale multiply,
//   truncation with saturation). Throughput: one transform per cycle, as
//   every stage takes a new request each cycle and nothing ever stalls.
//   Reset: arst_n low clears all stage valid bits; requests in flight are
//   dropped and no result is shown until new requests arrive.
//   Results are Q16.16; elements beyond the 32-bit range saturate.
// ----------------------------------------------------------------------------
module quat_scale_translate_matrix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  qstm_pkg::quat_comp_t quat_x,
	input  qstm_pkg::quat_comp_t quat_y,
	input  qstm_pkg::quat_comp_t quat_z,
	input  qstm_pkg::quat_comp_t quat_w,
	input  qstm_pkg::val_t       scale_x,
	input  qstm_pkg::val_t       scale_y,
	input  qstm_pkg::val_t       scale_z,
	input  qstm_pkg::val_t       move_x,
	input  qstm_pkg::val_t       move_y,
	input  qstm_pkg::val_t       move_z,
	output logic                 done,
	output qstm_pkg::val_t       col0_x,
	output qstm_pkg::val_t       col0_y,
	output qstm_pkg::val_t       col0_z,
	output qstm_pkg::val_t       col1_x,
	output qstm_pkg::val_t       col1_y,
	output qstm_pkg::val_t       col1_z,
	output qstm_pkg::val_t       col2_x,
	output qstm_pkg::val_t       col2_y,
	output qstm_pkg::val_t       col2_z,
	output qstm_pkg::val_t       tr_x,
	output qstm_pkg::val_t       tr_y,
	output qstm_pkg::val_t       tr_z
);
	import qstm_pkg::*;

	localparam int ROT_STAGES = 5;
	localparam int ALL_STAGES = 7;

	quat_t    quat;
	vec3_t    scale_in;
	vec3_t    move_in;
	logic     req;
	logic     rot_valid;
	rot_vec_t rot;
	rot_vec_t res;
	vec3_t    scale_d [ROT_STAGES];
	vec3_t    move_d  [ALL_STAGES];

	assign busy = 1'b0;
	assign req  = start & ~busy;

	assign quat     = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
	assign scale_in = '{x: scale_x, y: scale_y, z: scale_z};
	assign move_in  = '{x: move_x, y: move_y, z: move_z};

	// side payload rides along with the arithmetic stages
	always_ff @(posedge clk) begin
		scale_d[0] <= scale_in;
		for (int i = 1; i < ROT_STAGES; i++) begin
			scale_d[i] <= scale_d[i-1];
		end
		move_d[0] <= move_in;
		for (int i = 1; i < ALL_STAGES; i++) begin
			move_d[i] <= move_d[i-1];
		end
	end

	qstm_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req),
		.quat      (quat),
		.out_valid (rot_valid),
		.rot       (rot)
	);

	qstm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.rot       (rot),
		.scale     (scale_d[ROT_STAGES-1]),
		.out_valid (done),
		.res       (res)
	);

	assign col0_x = res[0];
	assign col0_y = res[1];
	assign col0_z = res[2];
	assign col1_x = res[3];
	assign col1_y = res[4];
	assign col1_z = res[5];
	assign col2_x = res[6];
	assign col2_y = res[7];
	assign col2_z = res[8];
	assign tr_x   = move_d[ALL_STAGES-1].x;
	assign tr_y   = move_d[ALL_STAGES-1].y;
	assign tr_z   = move_d[ALL_STAGES-1].z;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##7 done)
		else $error("request did not produce a result after 7 cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!req |-> ##7 !done)
		else $error("result without a matching request");

	a_translate: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##7 (tr_x == $past(move_x, 7) && tr_z == $past(move_z, 7)))
		else $error("translation misaligned with its request");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(req && quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
		|-> ##7 (col0_x == $past(scale_x, 7) && col2_z == $past(scale_z, 7)
			&& col1_x == '0))
		else $error("zero quaternion must give the plain scale matrix");
`endif

endmodule
